[design/csrfs_pkg.sv]
// csrfs_pkg: shared widths, config register indexes, payload structs and a
// helper multiplier for the hollow cylinder ray face selector.
// No dependencies.
package csrfs_pkg;

    // position fraction bits (lengths are signed Q.F)
    localparam int POS_FRAC_BITS = 16;

    localparam int DATA_W = 32;
    localparam int RSQ_W  = 48;
    localparam int HL_W   = 31;
    localparam int TOL_W  = 16;

    // disc offset saturates at 2^OFF_SAT_LOG
    localparam int OFF_SAT_LOG = 40;
    localparam int DIV_BITS    = OFF_SAT_LOG + 1;
    localparam int SAT_W       = DATA_W + OFF_SAT_LOG;

    // a hit coordinate wider than this is always beyond the outer radius
    localparam int SQ_W = (RSQ_W + POS_FRAC_BITS + 1) / 2;
    localparam int HX_W = DIV_BITS + 2;

    // config register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_RSQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_RSQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SURF_TOL  = 2'd3;
    localparam logic [TOL_W-1:0]     TOL_RESET     = 16'd7;

    typedef struct packed {
        logic [RSQ_W-1:0] inner_radius_sq;
        logic [RSQ_W-1:0] outer_radius_sq;
        logic [HL_W-1:0]  half_length;
        logic [TOL_W-1:0] surface_tolerance;
    } csrfs_cfg_t;

    // per-ray data needed to form the disc hit point
    typedef struct packed {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic dx_neg;
        logic dy_neg;
        logic neg_base;
        logic forward;
        logic disc_en;
        logic dz_pos;
    } csrfs_ray_t;

    // ray data plus finished inner-face decisions, carried past the divider
    typedef struct packed {
        csrfs_ray_t ray;
        logic sat_x;
        logic sat_y;
        logic cond;
        logic inner_q;
        logic lhs_lt;
        logic rhs_lt;
    } csrfs_side_t;

    typedef struct packed {
        csrfs_side_t       side;
        logic [63:0]       nx;
        logic [63:0]       ny;
        logic [DATA_W-1:0] adz;
    } csrfs_div_in_t;

    typedef struct packed {
        csrfs_side_t         side;
        logic [DIV_BITS-1:0] qx;
        logic [DIV_BITS-1:0] qy;
    } csrfs_div_out_t;

    typedef struct packed {
        logic take_inner;
        logic take_positive_disc;
        logic take_negative_disc;
        logic take_outer;
    } csrfs_result_t;

    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'b0, a} * {32'b0, b};
        return p;
    endfunction

endpackage

[design/csrfs_front.sv]
// csrfs_front: five pipeline stages of products, disc setup and the inner
// cylinder tests (exact cross-multiplied compares). Uses csrfs_pkg.
module csrfs_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [31:0]         pos_x,
    input  logic signed [31:0]         pos_y,
    input  logic signed [31:0]         pos_z,
    input  logic signed [31:0]         dir_x,
    input  logic signed [31:0]         dir_y,
    input  logic signed [31:0]         dir_z,
    input  csrfs_pkg::csrfs_cfg_t      cfg,
    output logic                       out_valid,
    output csrfs_pkg::csrfs_div_in_t   out_data
);

    typedef struct packed {
        csrfs_pkg::csrfs_ray_t ray;
        logic signed [63:0] pxx;
        logic signed [63:0] pyy;
        logic signed [63:0] pxdx;
        logic signed [63:0] pydy;
        logic signed [63:0] pxdy;
        logic signed [63:0] pydx;
        logic signed [63:0] dxx;
        logic signed [63:0] dyy;
        logic [31:0] adz;
        logic [31:0] anum;
        logic [31:0] adx;
        logic [31:0] ady;
    } st1_t;

    typedef struct packed {
        csrfs_pkg::csrfs_ray_t ray;
        logic        cond;
        logic [63:0] negdot;
        logic [63:0] den;
        logic [63:0] cm;
        logic [63:0] nx;
        logic [63:0] ny;
        logic [31:0] anum;
        logic [31:0] adz;
    } st2_t;

    typedef struct packed {
        csrfs_pkg::csrfs_ray_t ray;
        logic        cond;
        logic        sat_x;
        logic        sat_y;
        logic        den_nz;
        logic [63:0] l0;
        logic [63:0] l1;
        logic [63:0] r0;
        logic [63:0] r1;
        logic [63:0] c00;
        logic [63:0] c01;
        logic [63:0] c11;
        logic [63:0] kd00;
        logic [63:0] kd01;
        logic [63:0] kd10;
        logic [63:0] kd11;
        logic [63:0] kd20;
        logic [63:0] kd21;
        logic [63:0] nx;
        logic [63:0] ny;
        logic [31:0] adz;
    } st3_t;

    typedef struct packed {
        csrfs_pkg::csrfs_ray_t ray;
        logic         cond;
        logic         sat_x;
        logic         sat_y;
        logic         den_nz;
        logic [95:0]  lhs;
        logic [95:0]  rhs;
        logic [127:0] cmsq;
        logic [159:0] kd;
        logic [63:0]  nx;
        logic [63:0]  ny;
        logic [31:0]  adz;
    } st4_t;

    st1_t st1_next, st1_reg;
    st2_t st2_next, st2_reg;
    st3_t st3_next, st3_reg;
    st4_t st4_next, st4_reg;
    csrfs_pkg::csrfs_div_in_t st5_next, st5_reg;
    logic [4:0] valid_reg;

    // stage 1: magnitudes, disc plane distance and the raw products
    always_comb
    begin
        logic signed [33:0] zd;
        logic signed [33:0] num;
        logic [33:0]        num_mag;
        logic               dz_pos;
        zd      = '0;
        num     = '0;
        num_mag = '0;
        dz_pos  = !dir_z[31] && (dir_z != '0);
        zd      = dz_pos ? $signed({3'b000, cfg.half_length})
                         : -$signed({3'b000, cfg.half_length});
        num     = zd - $signed({{2{pos_z[31]}}, pos_z});
        num_mag = num[33] ? (~num + 34'd1) : num;

        st1_next.ray.px       = pos_x;
        st1_next.ray.py       = pos_y;
        st1_next.ray.dx_neg   = dir_x[31];
        st1_next.ray.dy_neg   = dir_y[31];
        st1_next.ray.neg_base = num[33] != dir_z[31];
        st1_next.ray.forward  = (num != '0) && ((!num[33]) == dz_pos);
        st1_next.ray.dz_pos   = dz_pos;
        st1_next.adz          = dir_z[31] ? (~dir_z + 32'd1) : dir_z;
        st1_next.ray.disc_en  = st1_next.adz > {2'b00, cfg.surface_tolerance, 14'b0};
        st1_next.anum         = num_mag[31:0];
        st1_next.adx          = dir_x[31] ? (~dir_x + 32'd1) : dir_x;
        st1_next.ady          = dir_y[31] ? (~dir_y + 32'd1) : dir_y;
        st1_next.pxx          = 64'(pos_x) * 64'(pos_x);
        st1_next.pyy          = 64'(pos_y) * 64'(pos_y);
        st1_next.pxdx         = 64'(pos_x) * 64'(dir_x);
        st1_next.pydy         = 64'(pos_y) * 64'(dir_y);
        st1_next.pxdy         = 64'(pos_x) * 64'(dir_y);
        st1_next.pydx         = 64'(pos_y) * 64'(dir_x);
        st1_next.dxx          = 64'(dir_x) * 64'(dir_x);
        st1_next.dyy          = 64'(dir_y) * 64'(dir_y);
    end

    // stage 2: inner tolerance and forward tests, cross term, disc numerators
    always_comb
    begin
        logic [63:0]        rpos2;
        logic [63:0]        inner64;
        logic [63:0]        diff;
        logic [63:0]        tl;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [64:0] cdiff;
        logic [64:0]        cneg;
        rpos2   = (64'(st1_reg.pxx) + 64'(st1_reg.pyy)) >> csrfs_pkg::POS_FRAC_BITS;
        inner64 = {16'b0, cfg.inner_radius_sq};
        diff    = (rpos2 > inner64) ? (rpos2 - inner64) : (inner64 - rpos2);
        tl      = ({48'b0, cfg.surface_tolerance} << csrfs_pkg::POS_FRAC_BITS) >> 16;
        a       = -st1_reg.pxdx;
        b       = st1_reg.pydy;
        cdiff   = {st1_reg.pxdy[63], st1_reg.pxdy} - {st1_reg.pydx[63], st1_reg.pydx};
        cneg    = ~cdiff + 65'd1;

        st2_next.ray    = st1_reg.ray;
        st2_next.cond   = (diff > tl) && (a > b);
        st2_next.negdot = a - b;
        st2_next.den    = st1_reg.dxx + st1_reg.dyy;
        st2_next.cm     = cdiff[64] ? cneg[63:0] : cdiff[63:0];
        st2_next.nx     = csrfs_pkg::mul32(st1_reg.anum, st1_reg.adx);
        st2_next.ny     = csrfs_pkg::mul32(st1_reg.anum, st1_reg.ady);
        st2_next.anum   = st1_reg.anum;
        st2_next.adz    = st1_reg.adz;
    end

    // stage 3: offset saturation check and 32x32 partial products
    always_comb
    begin
        logic [csrfs_pkg::SAT_W-1:0] sat_lim;
        logic [95:0]                 kw;
        sat_lim = (csrfs_pkg::SAT_W'(st2_reg.adz) << csrfs_pkg::OFF_SAT_LOG)
                  + csrfs_pkg::SAT_W'(st2_reg.adz);
        kw      = 96'(cfg.inner_radius_sq) << csrfs_pkg::POS_FRAC_BITS;

        st3_next.ray    = st2_reg.ray;
        st3_next.cond   = st2_reg.cond;
        st3_next.sat_x  = csrfs_pkg::SAT_W'(st2_reg.nx) >= sat_lim;
        st3_next.sat_y  = csrfs_pkg::SAT_W'(st2_reg.ny) >= sat_lim;
        st3_next.den_nz = st2_reg.den != '0;
        st3_next.l0     = csrfs_pkg::mul32(st2_reg.anum, st2_reg.den[31:0]);
        st3_next.l1     = csrfs_pkg::mul32(st2_reg.anum, st2_reg.den[63:32]);
        st3_next.r0     = csrfs_pkg::mul32(st2_reg.negdot[31:0], st2_reg.adz);
        st3_next.r1     = csrfs_pkg::mul32(st2_reg.negdot[63:32], st2_reg.adz);
        st3_next.c00    = csrfs_pkg::mul32(st2_reg.cm[31:0], st2_reg.cm[31:0]);
        st3_next.c01    = csrfs_pkg::mul32(st2_reg.cm[31:0], st2_reg.cm[63:32]);
        st3_next.c11    = csrfs_pkg::mul32(st2_reg.cm[63:32], st2_reg.cm[63:32]);
        st3_next.kd00   = csrfs_pkg::mul32(kw[31:0], st2_reg.den[31:0]);
        st3_next.kd01   = csrfs_pkg::mul32(kw[31:0], st2_reg.den[63:32]);
        st3_next.kd10   = csrfs_pkg::mul32(kw[63:32], st2_reg.den[31:0]);
        st3_next.kd11   = csrfs_pkg::mul32(kw[63:32], st2_reg.den[63:32]);
        st3_next.kd20   = csrfs_pkg::mul32(kw[95:64], st2_reg.den[31:0]);
        st3_next.kd21   = csrfs_pkg::mul32(kw[95:64], st2_reg.den[63:32]);
        st3_next.nx     = st2_reg.nx;
        st3_next.ny     = st2_reg.ny;
        st3_next.adz    = st2_reg.adz;
    end

    // stage 4: sum the partial products
    always_comb
    begin
        st4_next.ray    = st3_reg.ray;
        st4_next.cond   = st3_reg.cond;
        st4_next.sat_x  = st3_reg.sat_x;
        st4_next.sat_y  = st3_reg.sat_y;
        st4_next.den_nz = st3_reg.den_nz;
        st4_next.lhs    = 96'(st3_reg.l0) + (96'(st3_reg.l1) << 32);
        st4_next.rhs    = 96'(st3_reg.r0) + (96'(st3_reg.r1) << 32);
        st4_next.cmsq   = 128'(st3_reg.c00) + (128'(st3_reg.c01) << 33)
                          + (128'(st3_reg.c11) << 64);
        st4_next.kd     = 160'(st3_reg.kd00)
                          + (160'(st3_reg.kd01) << 32) + (160'(st3_reg.kd10) << 32)
                          + (160'(st3_reg.kd11) << 64) + (160'(st3_reg.kd20) << 64)
                          + (160'(st3_reg.kd21) << 96);
        st4_next.nx     = st3_reg.nx;
        st4_next.ny     = st3_reg.ny;
        st4_next.adz    = st3_reg.adz;
    end

    // stage 5: closest approach and clip compares
    always_comb
    begin
        st5_next.side.ray     = st4_reg.ray;
        st5_next.side.sat_x   = st4_reg.sat_x;
        st5_next.side.sat_y   = st4_reg.sat_y;
        st5_next.side.cond    = st4_reg.cond;
        st5_next.side.inner_q = st4_reg.den_nz && (160'(st4_reg.cmsq) < st4_reg.kd);
        st5_next.side.lhs_lt  = st4_reg.lhs < st4_reg.rhs;
        st5_next.side.rhs_lt  = st4_reg.rhs < st4_reg.lhs;
        st5_next.nx           = st4_reg.nx;
        st5_next.ny           = st4_reg.ny;
        st5_next.adz          = st4_reg.adz;
    end

    // stage payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            st4_reg <= st4_next;
            st5_reg <= st5_next;
        end
    end

    // valid bits travel with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    assign out_valid = valid_reg[4];
    assign out_data  = st5_reg;

endmodule

[design/csrfs_div.sv]
// csrfs_div: pipelined restoring divider, one quotient bit per stage, for the
// x and y disc offsets |num|*|d|/|dz|. Uses csrfs_pkg.
module csrfs_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  csrfs_pkg::csrfs_div_in_t   in_data,
    output logic                       out_valid,
    output csrfs_pkg::csrfs_div_out_t  out_data
);

    typedef struct packed {
        csrfs_pkg::csrfs_side_t        side;
        logic [63:0]                   nx;
        logic [63:0]                   ny;
        logic [31:0]                   adz;
        logic [31:0]                   rx;
        logic [31:0]                   ry;
        logic [csrfs_pkg::DIV_BITS-1:0] qx;
        logic [csrfs_pkg::DIV_BITS-1:0] qy;
    } dst_t;

    dst_t st_next [csrfs_pkg::DIV_BITS];
    dst_t st_reg  [csrfs_pkg::DIV_BITS];
    dst_t init;
    logic [csrfs_pkg::DIV_BITS-1:0] valid_reg;

    // one restoring step on both quotients
    function automatic dst_t div_step(input dst_t s, input logic [5:0] bitpos);
        dst_t        r;
        logic [32:0] tx;
        logic [32:0] ty;
        logic [32:0] dz;
        r  = s;
        dz = {1'b0, s.adz};
        tx = {s.rx, s.nx[bitpos]};
        ty = {s.ry, s.ny[bitpos]};
        if (tx >= dz)
        begin
            tx = tx - dz;
            r.qx[bitpos] = 1'b1;
        end
        if (ty >= dz)
        begin
            ty = ty - dz;
            r.qy[bitpos] = 1'b1;
        end
        r.rx = tx[31:0];
        r.ry = ty[31:0];
        return r;
    endfunction

    // leading remainder: the bits above the quotient range
    always_comb
    begin
        init.side = in_data.side;
        init.nx   = in_data.nx;
        init.ny   = in_data.ny;
        init.adz  = in_data.adz;
        init.rx   = 32'(in_data.nx >> csrfs_pkg::DIV_BITS);
        init.ry   = 32'(in_data.ny >> csrfs_pkg::DIV_BITS);
        init.qx   = '0;
        init.qy   = '0;
    end

    // stage k resolves quotient bit DIV_BITS-1-k
    always_comb
    begin
        st_next[0] = div_step(init, 6'(csrfs_pkg::DIV_BITS - 1));
        for (int k = 1; k < csrfs_pkg::DIV_BITS; k++)
        begin
            st_next[k] = div_step(st_reg[k-1], 6'(csrfs_pkg::DIV_BITS - 1 - k));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < csrfs_pkg::DIV_BITS; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[csrfs_pkg::DIV_BITS-2:0], in_valid};
        end
    end

    assign out_valid     = valid_reg[csrfs_pkg::DIV_BITS-1];
    assign out_data.side = st_reg[csrfs_pkg::DIV_BITS-1].side;
    assign out_data.qx   = st_reg[csrfs_pkg::DIV_BITS-1].qx;
    assign out_data.qy   = st_reg[csrfs_pkg::DIV_BITS-1].qy;

endmodule

[design/csrfs_back.sv]
// csrfs_back: disc hit point, hit radius test and the final face decision,
// ending in the output register. Uses csrfs_pkg.
module csrfs_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  csrfs_pkg::csrfs_div_out_t  in_data,
    input  csrfs_pkg::csrfs_cfg_t      cfg,
    output logic                       out_valid,
    output csrfs_pkg::csrfs_result_t   out_data
);

    localparam int CW = 2 * csrfs_pkg::SQ_W + 1;

    typedef struct packed {
        csrfs_pkg::csrfs_side_t side;
        logic signed [csrfs_pkg::HX_W-1:0] hx;
        logic signed [csrfs_pkg::HX_W-1:0] hy;
    } b1_t;

    typedef struct packed {
        csrfs_pkg::csrfs_side_t side;
        logic                        big;
        logic [csrfs_pkg::SQ_W-1:0] ax;
        logic [csrfs_pkg::SQ_W-1:0] ay;
    } b2_t;

    typedef struct packed {
        csrfs_pkg::csrfs_side_t side;
        logic                          big;
        logic [2*csrfs_pkg::SQ_W-1:0] sqx;
        logic [2*csrfs_pkg::SQ_W-1:0] sqy;
    } b3_t;

    b1_t b1_next, b1_reg;
    b2_t b2_next, b2_reg;
    b3_t b3_next, b3_reg;
    csrfs_pkg::csrfs_result_t res_next, res_reg;
    logic [3:0] valid_reg;

    // hit point: position plus the signed, saturated offset
    always_comb
    begin
        logic [csrfs_pkg::DIV_BITS-1:0]    offx;
        logic [csrfs_pkg::DIV_BITS-1:0]    offy;
        logic signed [csrfs_pkg::HX_W-1:0] pxe;
        logic signed [csrfs_pkg::HX_W-1:0] pye;
        logic signed [csrfs_pkg::HX_W-1:0] ox;
        logic signed [csrfs_pkg::HX_W-1:0] oy;
        offx = in_data.side.sat_x ? (csrfs_pkg::DIV_BITS'(1) << csrfs_pkg::OFF_SAT_LOG)
                                  : in_data.qx;
        offy = in_data.side.sat_y ? (csrfs_pkg::DIV_BITS'(1) << csrfs_pkg::OFF_SAT_LOG)
                                  : in_data.qy;
        pxe  = csrfs_pkg::HX_W'(in_data.side.ray.px);
        pye  = csrfs_pkg::HX_W'(in_data.side.ray.py);
        ox   = $signed({2'b00, offx});
        oy   = $signed({2'b00, offy});
        b1_next.side = in_data.side;
        b1_next.hx   = (in_data.side.ray.neg_base != in_data.side.ray.dx_neg) ? (pxe - ox)
                                                                             : (pxe + ox);
        b1_next.hy   = (in_data.side.ray.neg_base != in_data.side.ray.dy_neg) ? (pye - oy)
                                                                             : (pye + oy);
    end

    // magnitudes; anything past SQ_W bits is outside every outer radius
    always_comb
    begin
        logic [csrfs_pkg::HX_W-1:0] ahx;
        logic [csrfs_pkg::HX_W-1:0] ahy;
        ahx = b1_reg.hx[csrfs_pkg::HX_W-1] ? (~b1_reg.hx + csrfs_pkg::HX_W'(1)) : b1_reg.hx;
        ahy = b1_reg.hy[csrfs_pkg::HX_W-1] ? (~b1_reg.hy + csrfs_pkg::HX_W'(1)) : b1_reg.hy;
        b2_next.side = b1_reg.side;
        b2_next.big  = (|ahx[csrfs_pkg::HX_W-1:csrfs_pkg::SQ_W])
                       || (|ahy[csrfs_pkg::HX_W-1:csrfs_pkg::SQ_W]);
        b2_next.ax   = ahx[csrfs_pkg::SQ_W-1:0];
        b2_next.ay   = ahy[csrfs_pkg::SQ_W-1:0];
    end

    // squares
    always_comb
    begin
        b3_next.side = b2_reg.side;
        b3_next.big  = b2_reg.big;
        b3_next.sqx  = {{csrfs_pkg::SQ_W{1'b0}}, b2_reg.ax} * {{csrfs_pkg::SQ_W{1'b0}}, b2_reg.ax};
        b3_next.sqy  = {{csrfs_pkg::SQ_W{1'b0}}, b2_reg.ay} * {{csrfs_pkg::SQ_W{1'b0}}, b2_reg.ay};
    end

    // radius window and face decision
    always_comb
    begin
        logic [CW-1:0] s;
        logic [CW-1:0] lim_hi;
        logic [CW-1:0] lim_lo;
        logic          hit_disk;
        logic          hit_inner;
        s        = CW'(b3_reg.sqx) + CW'(b3_reg.sqy);
        lim_hi   = CW'(cfg.outer_radius_sq) << csrfs_pkg::POS_FRAC_BITS;
        lim_lo   = (CW'(cfg.inner_radius_sq) + CW'(1)) << csrfs_pkg::POS_FRAC_BITS;
        hit_disk = b3_reg.side.ray.disc_en && b3_reg.side.ray.forward && !b3_reg.big
                   && (s < lim_hi) && (s >= lim_lo);
        hit_inner = b3_reg.side.cond && b3_reg.side.inner_q
                    && !(hit_disk && b3_reg.side.lhs_lt);
        if (hit_inner && hit_disk && b3_reg.side.rhs_lt)
        begin
            hit_disk = 1'b0;
        end
        res_next.take_inner         = hit_inner;
        res_next.take_positive_disc = hit_disk && b3_reg.side.ray.dz_pos;
        res_next.take_negative_disc = hit_disk && !b3_reg.side.ray.dz_pos;
        res_next.take_outer         = !hit_inner && !hit_disk;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg  <= b1_next;
            b2_reg  <= b2_next;
            b3_reg  <= b3_next;
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[3];
    assign out_data  = res_reg;

endmodule

[design/cylinder_shell_ray_face_select.sv]
// cylinder_shell_ray_face_select: top level of the hollow cylinder face
// selector; config registers, stall control, stream ports.
// Depends on csrfs_pkg, csrfs_front, csrfs_div, csrfs_back.
//
//   channel  | direction | contents
//   s_*      | in        | one ray: pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
//   m_*      | out       | one result: four face flags
//   cfg_*    | in        | register write, index 0..3
//
// One ray per cycle enters while the pipeline is not frozen; each ray passes 5 setup
// stages, 41 divider stages one quotient bit each, then 4 final stages.
// The whole pipeline advances together; it freezes only while a result sits
// in the output register and m_tready is low, so nothing is dropped.
// Reset clears the valid bits and loads the register reset values.
module cylinder_shell_ray_face_select
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], dir_x[127:96], dir_y[159:128], dir_z[191:160]
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // take_inner[0], take_positive_disc[1], take_negative_disc[2], take_outer[3]
    output logic [7:0]   m_tdata,
    input  logic         cfg_write,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_data
);

    csrfs_pkg::csrfs_cfg_t     cfg_reg, cfg_next;
    csrfs_pkg::csrfs_div_in_t  front_data;
    csrfs_pkg::csrfs_div_out_t div_data;
    csrfs_pkg::csrfs_result_t  res;
    logic                      advance;
    logic                      front_valid;
    logic                      div_valid;

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                csrfs_pkg::CFG_INNER_RSQ: cfg_next.inner_radius_sq   = cfg_data;
                csrfs_pkg::CFG_OUTER_RSQ: cfg_next.outer_radius_sq   = cfg_data;
                csrfs_pkg::CFG_HALF_LEN:  cfg_next.half_length       = cfg_data[30:0];
                csrfs_pkg::CFG_SURF_TOL:  cfg_next.surface_tolerance = cfg_data[15:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inner_radius_sq   <= '0;
            cfg_reg.outer_radius_sq   <= '0;
            cfg_reg.half_length       <= '0;
            cfg_reg.surface_tolerance <= csrfs_pkg::TOL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // the pipeline moves whenever the output register can take a transaction
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    csrfs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (s_tvalid),
        .pos_x     ($signed(s_tdata[31:0])),
        .pos_y     ($signed(s_tdata[63:32])),
        .pos_z     ($signed(s_tdata[95:64])),
        .dir_x     ($signed(s_tdata[127:96])),
        .dir_y     ($signed(s_tdata[159:128])),
        .dir_z     ($signed(s_tdata[191:160])),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    csrfs_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    csrfs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .cfg       (cfg_reg),
        .out_valid (m_tvalid),
        .out_data  (res)
    );

    assign m_tdata = {4'b0000, res.take_outer, res.take_negative_disc,
                      res.take_positive_disc, res.take_inner};

    // outer is the fallback exactly when no other face is taken
    a_outer_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res.take_outer
                      == !(res.take_inner || res.take_positive_disc || res.take_negative_disc)))
        else $error("outer flag disagrees with the other faces");

    // at most one end disc per ray
    a_one_disc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(res.take_positive_disc && res.take_negative_disc))
        else $error("both end discs taken");

    // a stalled result freezes the whole pipeline, including the last divider stage
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(div_valid) && m_tvalid))
        else $error("pipeline moved during a stall");

endmodule

[bench/cylinder_shell_ray_face_select_tb.sv]
// cylinder_shell_ray_face_select_tb: self-checking bench for the hollow cylinder
// ray face selector; predicts the four face flags per ray and compares in order.
// Depends on csrfs_pkg and cylinder_shell_ray_face_select.
module cylinder_shell_ray_face_select_tb;

    localparam int F = csrfs_pkg::POS_FRAC_BITS;
    localparam int LATENCY = 50;
    localparam int WATCHDOG_LIMIT = 20000;

    // face prediction with its own copy of the registers
    class face_scoreboard;
        logic [47:0] rin_sq;
        logic [47:0] rout_sq;
        logic [30:0] half_len;
        logic [15:0] tol;
        csrfs_pkg::csrfs_result_t pending[$];
        int errors;

        function new();
            rin_sq = '0;
            rout_sq = '0;
            half_len = '0;
            tol = csrfs_pkg::TOL_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [47:0] val);
            case (idx)
                csrfs_pkg::CFG_INNER_RSQ: rin_sq = val;
                csrfs_pkg::CFG_OUTER_RSQ: rout_sq = val;
                csrfs_pkg::CFG_HALF_LEN:  half_len = val[30:0];
                default:                  tol = val[15:0];
            endcase
        endfunction

        // one hit coordinate: position plus truncated, saturated offset
        function logic signed [127:0] hit_coord(logic signed [63:0] p, logic [63:0] anum,
                                                logic signed [63:0] dc, logic [63:0] adz,
                                                bit neg_base);
            logic [127:0] off;
            logic [63:0] adc;
            adc = dc < 0 ? -dc : dc;
            off = (anum * adc) & 128'hFFFF_FFFF_FFFF_FFFF;
            off = off / adz;
            if (off > (128'd1 << 40))
                off = 128'd1 << 40;
            if (neg_base != (dc < 0))
                return p - $signed(off);
            return p + $signed(off);
        endfunction

        function csrfs_pkg::csrfs_result_t predict(logic [191:0] d);
            logic signed [63:0] px, py, pz, dx, dy, dz, zd, num, a, b, c1, c2;
            logic signed [127:0] hx, hy;
            logic [63:0] adz, anum, rpos2, tl, diff, negdot, den, cm;
            logic [127:0] s, lhs, rhs, q;
            bit hit_disk, hit_inner, fwd, nb, clipped;
            csrfs_pkg::csrfs_result_t r;
            px = $signed(d[31:0]);
            py = $signed(d[63:32]);
            pz = $signed(d[95:64]);
            dx = $signed(d[127:96]);
            dy = $signed(d[159:128]);
            dz = $signed(d[191:160]);
            adz = dz < 0 ? -dz : dz;
            anum = 0;
            hit_disk = 0;
            hit_inner = 0;
            // end disc test
            if (adz > ({48'd0, tol} << 14)) begin
                zd = dz > 0 ? $signed({33'd0, half_len}) : -$signed({33'd0, half_len});
                num = zd - pz;
                fwd = num != 0 && ((num > 0) == (dz > 0));
                nb = (num < 0) != (dz < 0);
                anum = num < 0 ? -num : num;
                hx = hit_coord(px, anum, dx, adz, nb);
                hy = hit_coord(py, anum, dy, adz, nb);
                if (hx < 0) hx = -hx;
                if (hy < 0) hy = -hy;
                s = hx * hx + hy * hy;
                hit_disk = fwd && s < ({80'd0, rout_sq} << F)
                           && !(s < ({79'd0, 49'(rin_sq) + 49'd1} << F));
            end
            // inner cylinder test
            rpos2 = (px * px + py * py) >> F;
            tl = ({48'd0, tol} << F) >> 16;
            diff = rpos2 > rin_sq ? rpos2 - rin_sq : rin_sq - rpos2;
            a = -(px * dx);
            b = py * dy;
            if (diff > tl && a > b) begin
                negdot = a - b;
                den = dx * dx + dy * dy;
                lhs = {64'd0, anum} * {64'd0, den};
                rhs = {64'd0, negdot} * {64'd0, adz};
                clipped = hit_disk && lhs < rhs;
                if (!clipped && den != 0) begin
                    c1 = px * dy;
                    c2 = py * dx;
                    cm = c1 >= c2 ? c1 - c2 : c2 - c1;
                    q = ({64'd0, cm} * {64'd0, cm}) / {64'd0, den};
                    hit_inner = q < ({80'd0, rin_sq} << F);
                end
                if (hit_inner && hit_disk && rhs < lhs)
                    hit_disk = 0;
            end
            r.take_inner = hit_inner;
            r.take_positive_disc = hit_disk && dz > 0;
            r.take_negative_disc = hit_disk && dz <= 0;
            r.take_outer = !hit_inner && !hit_disk;
            return r;
        endfunction

        function void note_ray(logic [191:0] d);
            pending.push_back(predict(d));
        endfunction

        function void check_flags(logic [7:0] got);
            csrfs_pkg::csrfs_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %b", $time, got[3:0]);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got[0] != e.take_inner) begin
                $display("%0t: take_inner exp %b got %b", $time, e.take_inner, got[0]);
                errors++;
            end
            if (got[1] != e.take_positive_disc) begin
                $display("%0t: take_positive_disc exp %b got %b", $time,
                         e.take_positive_disc, got[1]);
                errors++;
            end
            if (got[2] != e.take_negative_disc) begin
                $display("%0t: take_negative_disc exp %b got %b", $time,
                         e.take_negative_disc, got[2]);
                errors++;
            end
            if (got[3] != e.take_outer) begin
                $display("%0t: take_outer exp %b got %b", $time, e.take_outer, got[3]);
                errors++;
            end
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [7:0]   m_tdata;
    logic         cfg_write = 0;
    logic [1:0]   cfg_index = '0;
    logic [47:0]  cfg_data = '0;

    face_scoreboard sb = new();
    bit no_idle = 0;
    bit hold_sink = 0;
    int quiet_cycles = 0;

    cylinder_shell_ray_face_select u_dut (.*);

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // offer one ray and wait for its transaction, with random idle bursts
    task automatic send_ray(logic [191:0] d);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        do @(posedge clk); while (!s_tready);
        sb.note_ray(d);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // wait until every expected result has arrived, plus pipeline drain
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_pos(logic [30:0] hl);
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 2 * 65536 * 8) - 65536 * 8;
            2: return $urandom_range(0, 20 * 65536) - 10 * 65536;
            default: return $urandom_range(0, 2 * hl + 2) - hl - 1;
        endcase
    endfunction

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h4000_0000;
            2: return 32'hC000_0000;
            3: return '0;
            default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        endcase
    endfunction

    function automatic logic [191:0] rand_ray(logic [30:0] hl);
        return {rand_dir(), rand_dir(), rand_dir(),
                rand_pos(hl), rand_pos(hl), rand_pos(hl)};
    endfunction

    // result side: random stall bursts and one long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_sink) begin
                m_tready <= 0;
                repeat (300) @(posedge clk);
                hold_sink = 0;
            end
            else if (!no_idle && $urandom_range(0, 4) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else begin
                m_tready <= 1;
                @(posedge clk);
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready)
                sb.check_flags(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_write)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        logic [47:0] rin, rout;
        logic [30:0] hl;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed rays at reset settings
        send_ray('0);
        send_ray({32'h4000_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        drain();

        // unit-ish geometry: inner radius 1, outer 4, half length 5
        write_reg(csrfs_pkg::CFG_INNER_RSQ, 48'h1_0000);
        write_reg(csrfs_pkg::CFG_OUTER_RSQ, 48'h10_0000);
        write_reg(csrfs_pkg::CFG_HALF_LEN, 48'h5_0000);
        write_reg(csrfs_pkg::CFG_SURF_TOL, 48'd7);
        // disc hits toward +z and -z
        send_ray({32'h4000_0000, 32'd0, 32'd0, 32'd0, 32'h2_0000, 32'd0});
        send_ray({32'hC000_0000, 32'd0, 32'd0, 32'd0, 32'h2_0000, 32'd0});
        // radial ray toward axis: inner
        send_ray({32'd0, 32'd0, 32'hC000_0000, 32'd0, 32'd0, 32'h3_0000});
        // parallel to discs, away from axis: outer
        send_ray({32'd0, 32'd0, 32'h4000_0000, 32'd0, 32'd0, 32'h3_0000});
        // hit on the disc plane itself: not forward
        send_ray({32'h4000_0000, 32'd0, 32'd0, 32'h5_0000, 32'd0, 32'h2_0000});
        // large offset saturates
        send_ray({32'h0000_0001, 32'h4000_0000, 32'd0, 32'h8000_0000, 32'd0, 32'd0});
        // disc dropped by nearer inner face
        send_ray({32'h1000_0000, 32'd0, 32'hC000_0000, 32'd0, 32'd0, 32'h2_0000});
        // clipped: disc comes first
        send_ray({32'h7000_0000, 32'd0, 32'hA000_0000, 32'h4_0000, 32'd0, 32'h3_0000});
        // extreme fields
        send_ray({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
        send_ray({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        send_ray({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        drain();

        // extreme register settings, including zero tolerance
        write_reg(csrfs_pkg::CFG_INNER_RSQ, '1);
        write_reg(csrfs_pkg::CFG_OUTER_RSQ, '1);
        write_reg(csrfs_pkg::CFG_HALF_LEN, 48'h7FFF_FFFF);
        write_reg(csrfs_pkg::CFG_SURF_TOL, 48'hFFFF);
        send_ray({32'h4000_0000, 32'd0, 32'd0, 32'd0, 32'h2_0000, 32'd0});
        send_ray({32'h8000_0000, 32'h0000_0001, 32'h4000_0000, 32'h8000_0000, 32'd0, 32'd0});
        drain();
        write_reg(csrfs_pkg::CFG_SURF_TOL, 48'd0);
        write_reg(csrfs_pkg::CFG_INNER_RSQ, '0);
        send_ray({32'd0, 32'h4000_0000, 32'd0, 32'd0, 32'h1_0000, 32'h1_0000});
        send_ray({32'h0000_0001, 32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000});
        drain();

        // random phases, each with its own geometry
        for (int ph = 0; ph < 6; ph++)
        begin
            rin = 48'($urandom_range(0, 64)) << $urandom_range(10, 20);
            rout = rin + (48'($urandom_range(1, 256)) << $urandom_range(12, 22));
            hl = 31'($urandom_range(0, 32)) << $urandom_range(12, 20);
            if (ph == 5) begin
                rin = 48'({$urandom(), $urandom()});
                rout = 48'({$urandom(), $urandom()});
                hl = 31'($urandom());
            end
            write_reg(csrfs_pkg::CFG_INNER_RSQ, rin);
            write_reg(csrfs_pkg::CFG_OUTER_RSQ, rout);
            write_reg(csrfs_pkg::CFG_HALF_LEN, 48'(hl));
            write_reg(csrfs_pkg::CFG_SURF_TOL,
                      48'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 64)));
            if (ph == 1)
                hold_sink = 1;
            if (ph == 5)
                no_idle = 1;
            for (int i = 0; i < 300; i++)
                send_ray(rand_ray(hl));
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

[sim.f]
design/csrfs_pkg.sv
design/csrfs_front.sv
design/csrfs_div.sv
design/csrfs_back.sv
design/cylinder_shell_ray_face_select.sv
bench/cylinder_shell_ray_face_select_tb.sv
